[rtl/core/c_source_lexer_macros.svh]
// Assertion macros for the C source lexer checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef C_SOURCE_LEXER_MACROS_SVH
`define C_SOURCE_LEXER_MACROS_SVH

// same-cycle implication
`define CSLX_AST_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("c_source_lexer port check failed");

// next-cycle implication
`define CSLX_AST_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("c_source_lexer port check failed");

`endif

[rtl/core/cslx_pkg.sv]
// Package for the C source lexer: token and error codes, state types
// and the single-step lexing functions. No dependencies.
`default_nettype none

package cslx_pkg;

  localparam logic [5:0] TK_NONE             = 6'd0;
  localparam logic [5:0] TK_NE_OP            = 6'd1;
  localparam logic [5:0] TK_BOOL_NOT         = 6'd2;
  localparam logic [5:0] TK_HASH_HASH        = 6'd3;
  localparam logic [5:0] TK_HASH             = 6'd4;
  localparam logic [5:0] TK_MOD_ASSIGN       = 6'd5;
  localparam logic [5:0] TK_CLOSE_CURLY      = 6'd6;
  localparam logic [5:0] TK_MOD              = 6'd7;
  localparam logic [5:0] TK_AND_ASSIGN       = 6'd8;
  localparam logic [5:0] TK_AND_OP           = 6'd9;
  localparam logic [5:0] TK_AMPERSAND        = 6'd10;
  localparam logic [5:0] TK_OPEN_PAREN       = 6'd11;
  localparam logic [5:0] TK_CLOSE_PAREN      = 6'd12;
  localparam logic [5:0] TK_MUL_ASSIGN       = 6'd13;
  localparam logic [5:0] TK_MUL              = 6'd14;
  localparam logic [5:0] TK_ADD_ASSIGN       = 6'd15;
  localparam logic [5:0] TK_INC_OP           = 6'd16;
  localparam logic [5:0] TK_ADD              = 6'd17;
  localparam logic [5:0] TK_COMMA            = 6'd18;
  localparam logic [5:0] TK_SUB_ASSIGN       = 6'd19;
  localparam logic [5:0] TK_DEC_OP           = 6'd20;
  localparam logic [5:0] TK_PTR_OP           = 6'd21;
  localparam logic [5:0] TK_SUB              = 6'd22;
  localparam logic [5:0] TK_ELLIPSIS         = 6'd23;
  localparam logic [5:0] TK_DOT              = 6'd24;
  localparam logic [5:0] TK_DIV_ASSIGN       = 6'd25;
  localparam logic [5:0] TK_DIV              = 6'd26;
  localparam logic [5:0] TK_CLOSE_BRACKET    = 6'd27;
  localparam logic [5:0] TK_COLON            = 6'd28;
  localparam logic [5:0] TK_SEMICOLON        = 6'd29;
  localparam logic [5:0] TK_STRING_LITERAL   = 6'd30;
  localparam logic [5:0] TK_LEFT_ASSIGN      = 6'd31;
  localparam logic [5:0] TK_LEFT_OP          = 6'd32;
  localparam logic [5:0] TK_LE_OP            = 6'd33;
  localparam logic [5:0] TK_OPEN_CURLY       = 6'd34;
  localparam logic [5:0] TK_OPEN_BRACKET     = 6'd35;
  localparam logic [5:0] TK_LESS             = 6'd36;
  localparam logic [5:0] TK_EQ_OP            = 6'd37;
  localparam logic [5:0] TK_EQ               = 6'd38;
  localparam logic [5:0] TK_RIGHT_ASSIGN     = 6'd39;
  localparam logic [5:0] TK_RIGHT_OP         = 6'd40;
  localparam logic [5:0] TK_GE_OP            = 6'd41;
  localparam logic [5:0] TK_GREATER          = 6'd42;
  localparam logic [5:0] TK_QUESTION         = 6'd43;
  localparam logic [5:0] TK_XOR_ASSIGN       = 6'd44;
  localparam logic [5:0] TK_XOR              = 6'd45;
  localparam logic [5:0] TK_OR_ASSIGN        = 6'd46;
  localparam logic [5:0] TK_OR_OP            = 6'd47;
  localparam logic [5:0] TK_OR               = 6'd48;
  localparam logic [5:0] TK_BITWISE_NOT      = 6'd49;
  localparam logic [5:0] TK_BACKSLASH        = 6'd50;
  localparam logic [5:0] TK_NEWLINE          = 6'd51;
  localparam logic [5:0] TK_INTEGER_CONSTANT = 6'd52;
  localparam logic [5:0] TK_IDENTIFIER       = 6'd53;
  localparam logic [5:0] TK_EOF              = 6'd54;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_BAD_BYTE    = 3'd1;
  localparam logic [2:0] ERR_EMPTY_CHAR  = 3'd2;
  localparam logic [2:0] ERR_EOF_COMMENT = 3'd3;
  localparam logic [2:0] ERR_EOF_LITERAL = 3'd4;
  localparam logic [2:0] ERR_EOF_ESCAPE  = 3'd5;

  localparam logic [8:0] NOMATCH = 9'h100;

  localparam logic [7:0] CH_BSL = 8'h5C;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_USC = 8'h5F;

  // last-kind flag bits
  localparam int KF_ANY  = 0;
  localparam int KF_HASH = 1;
  localparam int KF_NL   = 2;

  typedef enum logic [3:0] {
    M_NORMAL = 4'd0, M_IDENT = 4'd1, M_NUMBER = 4'd2, M_BCOM = 4'd3, M_LCOM = 4'd4,
    M_CHR0 = 4'd5, M_CHR = 4'd6, M_STR0 = 4'd7, M_STR = 4'd8, M_PATH0 = 4'd9,
    M_PATH = 4'd10
  } lex_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_WIN, ST_END1, ST_END2
  } eng_state_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic       path_exp;
    logic [2:0] kf;
    logic [2:0] imp;
    logic [1:0] esc;
    logic [7:0] ppb;
  } lx_t;

  typedef struct packed {
    logic [5:0] ttype;
    logic [7:0] text;
    logic       has;
    logic       tstart;
    logic       tend;
    logic [2:0] err;
  } res_t;

  typedef struct packed {
    res_t r;
    logic last;
  } oitem_t;

  typedef struct packed {
    logic [1:0] k;
    logic       rv;
    res_t       r;
    lx_t        s;
  } step_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c == CH_USC) || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic [2:0] kind_of(logic [5:0] t);
    return {t == TK_NEWLINE, t == TK_HASH, 1'b1};
  endfunction

  function automatic logic [7:0] inc_char(logic [2:0] i);
    logic [7:0] ch;
    case (i)
      3'd1: ch = "n";
      3'd2: ch = "c";
      3'd3: ch = "l";
      3'd4: ch = "u";
      3'd5: ch = "d";
      3'd6: ch = "e";
      default: ch = "i";
    endcase
    return ch;
  endfunction

  function automatic res_t mk_res(logic [5:0] t, logic [7:0] text, logic has, logic st,
                                  logic en, logic [2:0] err);
    res_t r;
    r.ttype  = t;
    r.text   = text;
    r.has    = has;
    r.tstart = st;
    r.tend   = en;
    r.err    = err;
    return r;
  endfunction

  function automatic step_t tok(step_t o, logic [5:0] t, logic [1:0] k);
    step_t r;
    r      = o;
    r.rv   = 1'b1;
    r.r    = mk_res(t, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
    r.s.kf = kind_of(t);
    r.k    = k;
    return r;
  endfunction

  function automatic step_t op2(step_t o, logic dn, logic dp, logic [7:0] d,
                                logic [8:0] a, logic [5:0] ta, logic [8:0] b,
                                logic [5:0] tb, logic [8:0] x, logic [5:0] tx,
                                logic [5:0] t1);
    step_t r;
    r = o;
    if (dn) r.k = 2'd0;
    else if (dp && ({1'b0, d} == a)) r = tok(r, ta, 2'd2);
    else if (dp && ({1'b0, d} == b)) r = tok(r, tb, 2'd2);
    else if (dp && ({1'b0, d} == x)) r = tok(r, tx, 2'd2);
    else r = tok(r, t1, 2'd1);
    return r;
  endfunction

  function automatic step_t three(step_t o, logic en, logic ep, logic [7:0] e,
                                  logic [5:0] t3, logic [5:0] t2);
    step_t r;
    r = o;
    if (en) r.k = 2'd0;
    else if (ep && (e == "=")) r = tok(r, t3, 2'd3);
    else r = tok(r, t2, 2'd2);
    return r;
  endfunction

  function automatic step_t open_lit(step_t o, lex_mode_t m, logic [1:0] k);
    step_t r;
    r       = o;
    r.s.mode = m;
    r.s.esc = 2'd0;
    r.k     = k;
    return r;
  endfunction

  function automatic step_t word_byte(step_t o, logic [7:0] c, logic [7:0] d, logic dn,
                                      logic dp, logic start, logic ident);
    step_t      r;
    logic       more;
    logic [5:0] t;
    r = o;
    if (dn) begin
      r.k = 2'd0;
    end else begin
      more = dp && (ident ? (is_alpha(d) || is_digit(d)) : is_digit(d));
      if (ident) begin
        if (start) r.s.imp = (r.s.kf[KF_HASH] && (c == "i")) ? 3'd1 : 3'd0;
        else if ((r.s.imp >= 3'd1) && (r.s.imp <= 3'd6) && (c == inc_char(r.s.imp)))
          r.s.imp = r.s.imp + 3'd1;
        else r.s.imp = 3'd0;
      end
      r.rv = 1'b1;
      r.k  = 2'd1;
      if (more) begin
        r.r      = mk_res(TK_NONE, c, 1'b1, start, 1'b0, ERR_NONE);
        r.s.mode = ident ? M_IDENT : M_NUMBER;
      end else begin
        t        = ident ? TK_IDENTIFIER : TK_INTEGER_CONSTANT;
        r.r      = mk_res(t, c, 1'b1, start, 1'b1, ERR_NONE);
        r.s.kf   = kind_of(t);
        if (ident && (r.s.imp == 3'd7)) r.s.path_exp = 1'b1;
        r.s.mode = M_NORMAL;
      end
    end
    return r;
  endfunction

  function automatic step_t step_lit(step_t o, logic [7:0] c);
    step_t      r;
    logic       str;
    logic       first;
    logic [7:0] q;
    logic [5:0] t;
    r     = o;
    str   = (r.s.mode == M_STR0) || (r.s.mode == M_STR);
    first = (r.s.mode == M_CHR0) || (r.s.mode == M_STR0);
    q     = str ? CH_DQ : CH_SQ;
    r.k   = 2'd1;
    if (r.s.esc == 2'd1) begin
      r.rv    = 1'b1;
      r.r     = mk_res(TK_NONE, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
      r.s.esc = 2'd2;
    end else if (c == q) begin
      if (first && !str) begin
        r.rv = 1'b1;
        r.r  = mk_res(TK_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_EMPTY_CHAR);
      end else if (first) begin
        r = tok(r, TK_STRING_LITERAL, 2'd1);
      end else begin
        t      = str ? TK_STRING_LITERAL : TK_INTEGER_CONSTANT;
        r.rv   = 1'b1;
        r.r    = mk_res(t, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
        r.s.kf = kind_of(t);
      end
      if (str) r.s.path_exp = 1'b0;
      r.s.esc  = 2'd0;
      r.s.mode = M_NORMAL;
    end else begin
      r.rv     = 1'b1;
      r.r      = mk_res(TK_NONE, c, 1'b1, first, 1'b0, ERR_NONE);
      r.s.esc  = (c == CH_BSL) ? 2'd1 : 2'd0;
      r.s.mode = str ? M_STR : M_CHR;
    end
    return r;
  endfunction

  function automatic step_t step_path(step_t o, logic [7:0] c);
    step_t r;
    r   = o;
    r.k = 2'd1;
    if ((c == ">") && (r.s.ppb != CH_BSL)) begin
      if (r.s.mode == M_PATH0) begin
        r = tok(r, TK_STRING_LITERAL, 2'd1);
      end else begin
        r.rv   = 1'b1;
        r.r    = mk_res(TK_STRING_LITERAL, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
        r.s.kf = kind_of(TK_STRING_LITERAL);
      end
      r.s.path_exp = 1'b0;
      r.s.mode     = M_NORMAL;
    end else begin
      r.rv     = 1'b1;
      r.r      = mk_res(TK_NONE, c, 1'b1, r.s.mode == M_PATH0, 1'b0, ERR_NONE);
      r.s.ppb  = c;
      r.s.mode = M_PATH;
    end
    return r;
  endfunction

  function automatic step_t step_normal(step_t o, logic [7:0] c, logic [7:0] d,
                                        logic [7:0] e, logic dn, logic dp, logic en,
                                        logic ep);
    step_t r;
    r = o;
    case (c)
      "!": r = op2(r, dn, dp, d, "=", TK_NE_OP, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                   TK_BOOL_NOT);
      "#": r = op2(r, dn, dp, d, "#", TK_HASH_HASH, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                   TK_HASH);
      "%": r = op2(r, dn, dp, d, "=", TK_MOD_ASSIGN, ">", TK_CLOSE_CURLY, NOMATCH,
                   TK_NONE, TK_MOD);
      "&": r = op2(r, dn, dp, d, "=", TK_AND_ASSIGN, "&", TK_AND_OP, NOMATCH, TK_NONE,
                   TK_AMPERSAND);
      "(": r = tok(r, TK_OPEN_PAREN, 2'd1);
      ")": r = tok(r, TK_CLOSE_PAREN, 2'd1);
      "*": r = op2(r, dn, dp, d, "=", TK_MUL_ASSIGN, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                   TK_MUL);
      "+": r = op2(r, dn, dp, d, "=", TK_ADD_ASSIGN, "+", TK_INC_OP, NOMATCH, TK_NONE,
                   TK_ADD);
      ",": r = tok(r, TK_COMMA, 2'd1);
      "-": r = op2(r, dn, dp, d, "=", TK_SUB_ASSIGN, "-", TK_DEC_OP, ">", TK_PTR_OP,
                   TK_SUB);
      ".": begin
        if (dn) r.k = 2'd0;
        else if (dp && (d == ".") && en) r.k = 2'd0;
        else if (dp && (d == ".") && ep && (e == ".")) r = tok(r, TK_ELLIPSIS, 2'd3);
        else r = tok(r, TK_DOT, 2'd1);
      end
      "/": begin
        if (dn) r.k = 2'd0;
        else if (dp && (d == "=")) r = tok(r, TK_DIV_ASSIGN, 2'd2);
        else if (dp && (d == "*")) begin
          r.s.mode = M_BCOM;
          r.k      = 2'd2;
        end else if (dp && (d == "/")) begin
          r.s.mode = M_LCOM;
          r.k      = 2'd2;
        end else r = tok(r, TK_DIV, 2'd1);
      end
      ":": r = op2(r, dn, dp, d, ">", TK_CLOSE_BRACKET, NOMATCH, TK_NONE, NOMATCH,
                   TK_NONE, TK_COLON);
      ";": r = tok(r, TK_SEMICOLON, 2'd1);
      "<": begin
        if (r.s.path_exp) begin
          r.s.ppb  = 8'h00;
          r.s.mode = M_PATH0;
          r.k      = 2'd1;
        end else if (dn) r.k = 2'd0;
        else if (dp && (d == "<")) r = three(r, en, ep, e, TK_LEFT_ASSIGN, TK_LEFT_OP);
        else r = op2(r, dn, dp, d, "=", TK_LE_OP, "%", TK_OPEN_CURLY, ":",
                     TK_OPEN_BRACKET, TK_LESS);
      end
      "=": r = op2(r, dn, dp, d, "=", TK_EQ_OP, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                   TK_EQ);
      ">": begin
        if (dn) r.k = 2'd0;
        else if (dp && (d == ">")) r = three(r, en, ep, e, TK_RIGHT_ASSIGN, TK_RIGHT_OP);
        else r = op2(r, dn, dp, d, "=", TK_GE_OP, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                     TK_GREATER);
      end
      "?": r = tok(r, TK_QUESTION, 2'd1);
      "[": r = tok(r, TK_OPEN_BRACKET, 2'd1);
      "]": r = tok(r, TK_CLOSE_BRACKET, 2'd1);
      "^": r = op2(r, dn, dp, d, "=", TK_XOR_ASSIGN, NOMATCH, TK_NONE, NOMATCH, TK_NONE,
                   TK_XOR);
      "{": r = tok(r, TK_OPEN_CURLY, 2'd1);
      "|": r = op2(r, dn, dp, d, "=", TK_OR_ASSIGN, "|", TK_OR_OP, NOMATCH, TK_NONE,
                   TK_OR);
      "}": r = tok(r, TK_CLOSE_CURLY, 2'd1);
      "~": r = tok(r, TK_BITWISE_NOT, 2'd1);
      CH_BSL: r = tok(r, TK_BACKSLASH, 2'd1);
      CH_CR: begin
        if (dn) r.k = 2'd0;
        else r = tok(r, TK_NEWLINE, (dp && (d == CH_LF)) ? 2'd2 : 2'd1);
      end
      CH_LF: r = tok(r, TK_NEWLINE, 2'd1);
      CH_TAB, " ": r.k = 2'd1;
      CH_SQ: r = open_lit(r, M_CHR0, 2'd1);
      CH_DQ: r = open_lit(r, M_STR0, 2'd1);
      "L", "U", "u": begin
        if (dn) r.k = 2'd0;
        else if ((c == "L") && dp && (d == CH_SQ)) r = open_lit(r, M_CHR0, 2'd2);
        else if (dp && (d == CH_DQ)) r = open_lit(r, M_STR0, 2'd2);
        else if ((c == "u") && dp && (d == "8") && en) r.k = 2'd0;
        else if ((c == "u") && dp && (d == "8") && ep && (e == CH_DQ))
          r = open_lit(r, M_STR0, 2'd3);
        else r = word_byte(r, c, d, dn, dp, 1'b1, 1'b1);
      end
      default: begin
        if (is_digit(c)) r = word_byte(r, c, d, dn, dp, 1'b1, 1'b0);
        else if (is_alpha(c)) r = word_byte(r, c, d, dn, dp, 1'b1, 1'b1);
        else begin
          r.rv = 1'b1;
          r.r  = mk_res(TK_NONE, 8'h00, 1'b0, 1'b0, 1'b0, ERR_BAD_BYTE);
          r.k  = 2'd1;
        end
      end
    endcase
    return r;
  endfunction

  // One lexing step on a window of n bytes c, d, e.
  function automatic step_t step_one(lx_t s, logic [7:0] c, logic [7:0] d, logic [7:0] e,
                                     logic [1:0] n, logic wend);
    step_t o;
    logic  dp;
    logic  dn;
    logic  ep;
    logic  en;
    o.k  = 2'd0;
    o.rv = 1'b0;
    o.r  = '0;
    o.s  = s;
    dp   = (n >= 2'd2);
    dn   = !dp && !wend;
    ep   = (n == 2'd3);
    en   = !ep && !wend;
    case (s.mode)
      M_IDENT:  o = word_byte(o, c, d, dn, dp, 1'b0, 1'b1);
      M_NUMBER: o = word_byte(o, c, d, dn, dp, 1'b0, 1'b0);
      M_BCOM: begin
        if (c != "*") o.k = 2'd1;
        else if (dn) o.k = 2'd0;
        else if (dp && (d == "/")) begin
          o.s.mode = M_NORMAL;
          o.k      = 2'd2;
        end else o.k = 2'd1;
      end
      M_LCOM: begin
        if (c == CH_LF) begin
          o        = tok(o, TK_NEWLINE, 2'd1);
          o.s.mode = M_NORMAL;
        end else if (c != CH_CR) o.k = 2'd1;
        else if (dn) o.k = 2'd0;
        else begin
          o        = tok(o, TK_NEWLINE, (dp && (d == CH_LF)) ? 2'd2 : 2'd1);
          o.s.mode = M_NORMAL;
        end
      end
      M_CHR0, M_CHR, M_STR0, M_STR: o = step_lit(o, c);
      M_PATH0, M_PATH: o = step_path(o, c);
      default: begin
        o.s.mode = M_NORMAL;
        o = step_normal(o, c, d, e, dn, dp, en, ep);
      end
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

[rtl/core/cslx_fifo.sv]
// Small register FIFO, used for the byte queue and the result queue.
// Depends on nothing.
`default_nettype none

module cslx_fifo #(
  parameter int W     = 9,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wp_nxt  = do_wr ? ((wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1)) : wp_r;
    rp_nxt  = do_rd ? ((rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1)) : rp_r;
    cnt_nxt = cnt_r + CW'(do_wr) - CW'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
  end

endmodule

`default_nettype wire

[rtl/core/cslx_engine.sv]
// Lexing engine: window of up to three bytes, one step per cycle while the
// result queue has room, plus a one-step look-ahead to close items early;
// holds one result to tag last. Depends on cslx_pkg.
`default_nettype none

module cslx_engine (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            iq_empty,
  input  wire logic [8:0]      iq_data,
  output logic                 iq_pop,
  input  wire logic            oq_full,
  output logic                 oq_push,
  output cslx_pkg::oitem_t     oq_data
);

  cslx_pkg::eng_state_t state_r, state_nxt;
  cslx_pkg::lx_t        lx_r, lx_nxt;
  logic [2:0][7:0]      lb_r, lb_nxt;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 wend_r, wend_nxt;
  logic                 halted_r, halted_nxt;
  cslx_pkg::res_t       pend_r, pend_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic                 pend_fin_r, pend_fin_nxt;

  logic                 go;
  logic [2:0][7:0]      w, sw;
  logic [1:0]           n, na;
  logic                 wend;
  cslx_pkg::step_t      sa, sb;
  logic                 done_win;
  logic                 end_nl;
  cslx_pkg::res_t       end_r;
  logic                 r_v, d;
  cslx_pkg::res_t       r;

  // window and the two steps
  always_comb begin
    go   = !oq_full;
    w    = lb_r;
    n    = cnt_r;
    wend = wend_r;
    if (state_r == cslx_pkg::ST_IDLE) begin
      wend = iq_data[8];
      n    = cnt_r + {1'b0, !iq_data[8]};
      if (!iq_data[8]) w[cnt_r] = iq_data[7:0];
    end
    sa = cslx_pkg::step_one(lx_r, w[0], w[1], w[2], n, wend);
    case (sa.k)
      2'd1:    sw = {8'h00, w[2], w[1]};
      2'd2:    sw = {8'h00, 8'h00, w[2]};
      2'd3:    sw = '0;
      default: sw = w;
    endcase
    na = n - sa.k;
    sb = cslx_pkg::step_one(sa.s, sw[0], sw[1], sw[2], na, wend);
    done_win = (n == 2'd0) || (sa.k == 2'd0) || (na == 2'd0) || (sb.k == 2'd0);

    end_nl = 1'b0;
    end_r  = cslx_pkg::mk_res(cslx_pkg::TK_EOF, 8'h00, 1'b0, 1'b1, 1'b1,
                              cslx_pkg::ERR_NONE);
    case (lx_r.mode)
      cslx_pkg::M_BCOM, cslx_pkg::M_LCOM:
        end_r = cslx_pkg::mk_res(cslx_pkg::TK_NONE, 8'h00, 1'b0, 1'b0, 1'b0,
                                 cslx_pkg::ERR_EOF_COMMENT);
      cslx_pkg::M_CHR0, cslx_pkg::M_CHR, cslx_pkg::M_STR0, cslx_pkg::M_STR:
        end_r = cslx_pkg::mk_res(cslx_pkg::TK_NONE, 8'h00, 1'b0, 1'b0, 1'b0,
                                 (lx_r.esc != 2'd0) ? cslx_pkg::ERR_EOF_ESCAPE
                                                    : cslx_pkg::ERR_EOF_LITERAL);
      cslx_pkg::M_PATH0, cslx_pkg::M_PATH:
        end_r = cslx_pkg::mk_res(cslx_pkg::TK_NONE, 8'h00, 1'b0, 1'b0, 1'b0,
                                 cslx_pkg::ERR_EOF_LITERAL);
      default:
        end_nl = lx_r.kf[cslx_pkg::KF_ANY] && !lx_r.kf[cslx_pkg::KF_NL];
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cslx_pkg::ST_IDLE: begin
        if (go && !iq_empty && !halted_r) begin
          if (!done_win) state_nxt = cslx_pkg::ST_WIN;
          else if (wend) state_nxt = cslx_pkg::ST_END1;
        end
      end
      cslx_pkg::ST_WIN: begin
        if (go && done_win) state_nxt = wend ? cslx_pkg::ST_END1 : cslx_pkg::ST_IDLE;
      end
      cslx_pkg::ST_END1: begin
        if (go) state_nxt = end_nl ? cslx_pkg::ST_END2 : cslx_pkg::ST_IDLE;
      end
      cslx_pkg::ST_END2: begin
        if (go) state_nxt = cslx_pkg::ST_IDLE;
      end
      default: state_nxt = cslx_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    iq_pop     = 1'b0;
    r_v        = 1'b0;
    r          = sa.r;
    d          = 1'b0;
    lx_nxt     = lx_r;
    lb_nxt     = lb_r;
    cnt_nxt    = cnt_r;
    wend_nxt   = wend_r;
    halted_nxt = halted_r;
    case (state_r)
      cslx_pkg::ST_IDLE, cslx_pkg::ST_WIN: begin
        if (go && (state_r == cslx_pkg::ST_WIN || !iq_empty)) begin
          iq_pop = (state_r == cslx_pkg::ST_IDLE);
          if (state_r == cslx_pkg::ST_IDLE && halted_r) begin
            d = 1'b1;
          end else begin
            wend_nxt = wend;
            if (n != 2'd0) begin
              lx_nxt = sa.s;
              r_v    = sa.rv;
            end
            lb_nxt  = sw;
            cnt_nxt = na;
            if (done_win) begin
              d = !wend;
              if (wend) cnt_nxt = 2'd0;
            end
          end
        end
      end
      cslx_pkg::ST_END1: begin
        if (go) begin
          r_v = 1'b1;
          if (end_nl) begin
            r         = cslx_pkg::mk_res(cslx_pkg::TK_NEWLINE, 8'h00, 1'b0, 1'b1, 1'b1,
                                         cslx_pkg::ERR_NONE);
            lx_nxt.kf = cslx_pkg::kind_of(cslx_pkg::TK_NEWLINE);
          end else begin
            r          = end_r;
            d          = 1'b1;
            halted_nxt = 1'b1;
          end
        end
      end
      cslx_pkg::ST_END2: begin
        if (go) begin
          r_v        = 1'b1;
          r          = cslx_pkg::mk_res(cslx_pkg::TK_EOF, 8'h00, 1'b0, 1'b1, 1'b1,
                                        cslx_pkg::ERR_NONE);
          d          = 1'b1;
          halted_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // held result: pushed once the next result or the end of its item is known
  always_comb begin
    oq_push      = 1'b0;
    oq_data.r    = pend_r;
    oq_data.last = pend_fin_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    pend_fin_nxt = pend_fin_r;
    if (go) begin
      if (pend_v_r) begin
        if (r_v) begin
          oq_push      = 1'b1;
          pend_nxt     = r;
          pend_fin_nxt = d;
        end else if (pend_fin_r || d) begin
          oq_push      = 1'b1;
          oq_data.last = 1'b1;
          pend_v_nxt   = 1'b0;
        end
      end else if (r_v) begin
        pend_v_nxt   = 1'b1;
        pend_nxt     = r;
        pend_fin_nxt = d;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cslx_pkg::ST_IDLE;
      lx_r       <= '{mode: cslx_pkg::M_NORMAL, default: '0};
      cnt_r      <= 2'd0;
      wend_r     <= 1'b0;
      halted_r   <= 1'b0;
      pend_v_r   <= 1'b0;
      pend_fin_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lx_r       <= lx_nxt;
      cnt_r      <= cnt_nxt;
      wend_r     <= wend_nxt;
      halted_r   <= halted_nxt;
      pend_v_r   <= pend_v_nxt;
      pend_fin_r <= pend_fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lb_r   <= lb_nxt;
    pend_r <= pend_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/c_source_lexer.sv]
// C source lexer top level: byte queue, lexing engine, result queue.
// Depends on cslx_pkg, cslx_fifo, cslx_engine.
//
//   channel  | handshake          | payload
//   in_      | in_valid/in_stall  | char_code[7:0], end_of_input
//   out_     | out_valid/out_stall| token_type, text_byte, has_text, token_start,
//            |                    | token_end, error_code, last
//
// One byte a cycle while results drain; the engine pops a byte in its idle state and
// takes further steps that its three-byte window resolves at once in its window state.
// End of input adds end of file, after a newline if the last token was not one, or an error
// if it ends in a comment or literal. Results are held to mark last, then queued.
// Synchronous active-low reset empties both queues and returns to normal mode.
// A full result queue stalls the engine; a full byte queue raises in_stall.
`default_nettype none

module c_source_lexer #(
  parameter int IQ_DEPTH = 4,
  parameter int OQ_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      out_token_type,
  output logic [7:0]      out_text_byte,
  output logic            out_has_text,
  output logic            out_token_start,
  output logic            out_token_end,
  output logic [2:0]      out_error_code,
  output logic            out_last
);

  logic             iq_full, iq_empty, iq_pop;
  logic [8:0]       iq_data;
  logic             oq_full, oq_empty, oq_push;
  cslx_pkg::oitem_t oq_wdata, oq_rdata;

  cslx_fifo #(.W(9), .DEPTH(IQ_DEPTH)) u_iq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_valid),
    .wr_data ({in_end_of_input, in_char_code}),
    .full    (iq_full),
    .rd_en   (iq_pop),
    .rd_data (iq_data),
    .empty   (iq_empty)
  );

  cslx_engine u_eng (
    .clk      (clk),
    .rst_n    (rst_n),
    .iq_empty (iq_empty),
    .iq_data  (iq_data),
    .iq_pop   (iq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_data  (oq_wdata)
  );

  cslx_fifo #(.W($bits(cslx_pkg::oitem_t)), .DEPTH(OQ_DEPTH)) u_oq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (oq_push),
    .wr_data (oq_wdata),
    .full    (oq_full),
    .rd_en   (out_valid && !out_stall),
    .rd_data (oq_rdata),
    .empty   (oq_empty)
  );

  assign in_stall        = iq_full;
  assign out_valid       = !oq_empty;
  assign out_token_type  = oq_rdata.r.ttype;
  assign out_text_byte   = oq_rdata.r.text;
  assign out_has_text    = oq_rdata.r.has;
  assign out_token_start = oq_rdata.r.tstart;
  assign out_token_end   = oq_rdata.r.tend;
  assign out_error_code  = oq_rdata.r.err;
  assign out_last        = oq_rdata.last;

endmodule

`default_nettype wire

[rtl/core/cslx_checker.sv]
// Port checker for the C source lexer, bound to the top level.
// Depends on c_source_lexer_macros.svh and cslx_pkg.
`default_nettype none
`include "c_source_lexer_macros.svh"

module cslx_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [5:0] out_token_type,
  input wire logic [7:0] out_text_byte,
  input wire logic       out_has_text,
  input wire logic       out_token_end,
  input wire logic [2:0] out_error_code
);

  `CSLX_AST_NXT(a_out_hold, out_valid && out_stall, out_valid)
  `CSLX_AST_NOW(a_type_at_end, out_valid && !out_token_end, out_token_type == cslx_pkg::TK_NONE)
  `CSLX_AST_NOW(a_text_clear, out_valid && !out_has_text, out_text_byte == 8'h00)
  `CSLX_AST_NOW(a_err_alone, out_valid && (out_error_code != cslx_pkg::ERR_NONE),
                !out_has_text && !out_token_end)

endmodule

bind c_source_lexer cslx_checker u_cslx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_token_type (out_token_type),
  .out_text_byte  (out_text_byte),
  .out_has_text   (out_has_text),
  .out_token_end  (out_token_end),
  .out_error_code (out_error_code)
);

`default_nettype wire
